// ===== design/dalb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dalb_pkg: shared definitions for the disk activity LED blinker
// Command codes, configuration register indexes, brightness levels and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dalb_pkg;

    // Item field widths.
    localparam int CMD_W   = 3;
    localparam int UNIT_W  = 2;
    localparam int DISK_W  = 4;
    localparam int LEDN_W  = 4;
    localparam int LEVEL_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int LED_COUNT_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_DELAY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY = 3'd5;

    localparam logic [CFG_DATA_W-1:0] ACT_DELAY_RESET  = 10'd100;
    localparam logic [CFG_DATA_W-1:0] HOLD_DELAY_RESET = 10'd150;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ACTIVITY  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_FAULT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MAP_WRITE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIRECT    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MAP_CLEAR = 3'd5;

    // Brightness levels.
    localparam logic [LEVEL_W-1:0] BRIGHT_OFF  = 8'd0;
    localparam logic [LEVEL_W-1:0] BRIGHT_HALF = 8'd127;
    localparam logic [LEVEL_W-1:0] BRIGHT_FULL = 8'd255;

    // Address source for the LED state memory read port.
    typedef enum logic [1:0] {
        LRD_ITEM  = 2'd0,
        LRD_MAP   = 2'd1,
        LRD_FIRST = 2'd2,
        LRD_NEXT  = 2'd3
    } t_led_rd;

    typedef struct packed {
        logic    latch;
        logic    map_rd;
        logic    map_wr;
        logic    map_clr;
        logic    led_rd;
        t_led_rd led_sel;
        logic    act_wr;
        logic    fault_wr;
        logic    direct_emit;
        logic    sweep_start;
        logic    sweep_step;
        logic    flush;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             unit_ok;
        logic             led_ok;
        logic             disk_ok;
        logic             act_ok;
        logic             out_free;
        logic             sw_stall;
        logic             sw_last;
        logic             pend_valid;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== design/dalb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dalb_ctrl: item sequencer
// Accepts one item at a time and steps the datapath through the command.
// ----------------------------------------------------------------------------
module dalb_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output dalb_pkg::t_dp_cmd      o_cmd,
    input  dalb_pkg::t_dp_sts      i_sts
);
    import dalb_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_DISPATCH   = 8'b0000_0010,
        S_ACT_LED    = 8'b0000_0100,
        S_ACT_WR     = 8'b0000_1000,
        S_FAULT_WR   = 8'b0001_0000,
        S_DIRECT     = 8'b0010_0000,
        S_TICK_RUN   = 8'b0100_0000,
        S_TICK_FLUSH = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_IDLE;
                if (i_sts.cmd == CMD_TICK) begin
                    o_cmd.led_rd      = 1'b1;
                    o_cmd.led_sel     = LRD_FIRST;
                    o_cmd.sweep_start = 1'b1;
                    n_state           = S_TICK_RUN;
                end else if (i_sts.unit_ok) begin
                    case (i_sts.cmd)
                        CMD_ACTIVITY: begin
                            o_cmd.map_rd = 1'b1;
                            n_state      = S_ACT_LED;
                        end
                        CMD_SET_FAULT: begin
                            if (i_sts.led_ok) begin
                                o_cmd.led_rd  = 1'b1;
                                o_cmd.led_sel = LRD_ITEM;
                                n_state       = S_FAULT_WR;
                            end
                        end
                        CMD_MAP_WRITE: begin
                            o_cmd.map_wr = i_sts.disk_ok && i_sts.led_ok;
                        end
                        CMD_DIRECT: begin
                            if (i_sts.led_ok) begin
                                n_state = S_DIRECT;
                            end
                        end
                        CMD_MAP_CLEAR: begin
                            o_cmd.map_clr = 1'b1;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACT_LED: begin
                n_state = S_IDLE;
                if (i_sts.act_ok) begin
                    o_cmd.led_rd  = 1'b1;
                    o_cmd.led_sel = LRD_MAP;
                    n_state       = S_ACT_WR;
                end
            end
            S_ACT_WR: begin
                o_cmd.act_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_FAULT_WR: begin
                o_cmd.fault_wr = 1'b1;
                n_state        = S_IDLE;
            end
            S_DIRECT: begin
                if (i_sts.out_free) begin
                    o_cmd.direct_emit = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_TICK_RUN: begin
                if (!i_sts.sw_stall) begin
                    o_cmd.sweep_step = 1'b1;
                    o_cmd.led_rd     = 1'b1;
                    o_cmd.led_sel    = LRD_NEXT;
                    if (i_sts.sw_last) begin
                        n_state = S_TICK_FLUSH;
                    end
                end
            end
            S_TICK_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== design/dalb_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dalb_datapath: LED state, disk map and result registers
// Holds the per-LED state memory, the disk-to-LED map and the result path.
// ----------------------------------------------------------------------------
module dalb_datapath #(
    parameter int UNITS          = 4,
    parameter int LEDS_PER_UNIT  = 16,
    parameter int DISKS_PER_UNIT = 16,
    parameter int DELAY_BITS     = 10
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  dalb_pkg::t_dp_cmd                               i_cmd,
    output dalb_pkg::t_dp_sts                               o_sts,
    input  wire logic [dalb_pkg::CMD_W-1:0]                 i_cmd_code,
    input  wire logic [dalb_pkg::UNIT_W-1:0]                i_unit,
    input  wire logic [dalb_pkg::DISK_W-1:0]                i_disk,
    input  wire logic [dalb_pkg::LEDN_W-1:0]                i_led,
    input  wire logic                                       i_faulty,
    input  wire logic [dalb_pkg::LEVEL_W-1:0]               i_level,
    input  wire logic [UNITS-1:0][dalb_pkg::LED_COUNT_W-1:0] i_led_count,
    input  wire logic [DELAY_BITS-1:0]                      i_act_delay,
    input  wire logic [DELAY_BITS-1:0]                      i_hold_delay,
    output logic                                            o_out_valid,
    input  wire logic                                       i_out_ready,
    output logic [dalb_pkg::UNIT_W-1:0]                     o_out_unit,
    output logic [dalb_pkg::LEDN_W-1:0]                     o_out_led,
    output logic [dalb_pkg::LEVEL_W-1:0]                    o_brightness,
    output logic                                            o_last
);
    import dalb_pkg::*;

    localparam int LED_SLOTS = UNITS * LEDS_PER_UNIT;
    localparam int MAP_SLOTS = UNITS * DISKS_PER_UNIT;
    localparam int LS_W      = (LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1;
    localparam int MS_W      = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
    localparam int LED_W     = (LEDS_PER_UNIT > 1) ? $clog2(LEDS_PER_UNIT) : 1;
    localparam int US_W      = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int WORD_W    = DELAY_BITS + 2;

    // An LED number is usable when it is below both the unit's count and the
    // built-in LED limit; a unit beyond the configured units has no LEDs.
    function automatic logic led_ok_f(
        input logic [UNITS-1:0][LED_COUNT_W-1:0] counts,
        input logic [UNIT_W-1:0]                 unit,
        input logic [LED_COUNT_W-1:0]            led
    );
        logic ok;
        ok = 1'b0;
        for (int u = 0; u < UNITS; u++) begin
            if (unit == UNIT_W'(u)) begin
                ok = (led < LED_COUNT_W'(LEDS_PER_UNIT)) && (led < counts[u]);
            end
        end
        return ok;
    endfunction

    // Latched item.
    logic [CMD_W-1:0]   r_cmd;
    logic [UNIT_W-1:0]  r_unit;
    logic [DISK_W-1:0]  r_disk;
    logic [LEDN_W-1:0]  r_led;
    logic               r_faulty;
    logic [LEVEL_W-1:0] r_level;

    // Disk map: valid bits stand for the unmapped reset state.
    logic [LED_W-1:0]     map_mem [MAP_SLOTS];
    logic [MAP_SLOTS-1:0] r_map_vld;
    logic [LED_W-1:0]     r_map_rd_data;
    logic                 r_map_rd_vld;

    // LED state memory: {activity seen, faulty, countdown}.
    logic [WORD_W-1:0]    led_mem [LED_SLOTS];
    logic [LED_SLOTS-1:0] r_led_vld;
    logic [WORD_W-1:0]    r_led_rd_data;
    logic                 r_led_rd_vld;
    logic [LS_W-1:0]      r_led_addr;

    // Sweep position of the entry held in the read register.
    logic [US_W-1:0]  r_sw_unit;
    logic [LED_W-1:0] r_sw_led;

    // Pending tick result and output register.
    logic               r_pend_valid;
    logic [UNIT_W-1:0]  r_pend_unit;
    logic [LEDN_W-1:0]  r_pend_led;
    logic [LEVEL_W-1:0] r_pend_bright;
    logic               r_out_valid;
    logic [UNIT_W-1:0]  r_out_unit;
    logic [LEDN_W-1:0]  r_out_led;
    logic [LEVEL_W-1:0] r_out_bright;
    logic               r_out_last;

    logic                  unit_ok;
    logic                  disk_ok;
    logic                  led_ok;
    logic                  act_ok;
    logic                  out_free;
    logic [LS_W-1:0]       item_slot;
    logic [LS_W-1:0]       mapped_slot;
    logic [MS_W-1:0]       map_slot;
    logic [LS_W-1:0]       rd_addr;
    logic                  e_seen;
    logic                  e_fault;
    logic [DELAY_BITS-1:0] e_cnt;
    logic                  sw_expire;
    logic                  wr_en;
    logic [WORD_W-1:0]     wr_data;
    logic                  res_need;
    logic [LEVEL_W-1:0]    res_bright;

    assign unit_ok     = int'(r_unit) < UNITS;
    assign disk_ok     = int'(r_disk) < DISKS_PER_UNIT;
    assign led_ok      = led_ok_f(i_led_count, r_unit, LED_COUNT_W'(r_led));
    assign act_ok      = unit_ok && disk_ok && r_map_rd_vld &&
                         led_ok_f(i_led_count, r_unit, LED_COUNT_W'(r_map_rd_data));
    assign out_free    = !r_out_valid || i_out_ready;
    assign item_slot   = LS_W'(int'(r_unit) * LEDS_PER_UNIT + int'(r_led));
    assign mapped_slot = LS_W'(int'(r_unit) * LEDS_PER_UNIT + int'(r_map_rd_data));
    assign map_slot    = MS_W'(int'(r_unit) * DISKS_PER_UNIT + int'(r_disk));

    // Entries never written read as the reset state.
    assign e_seen  = r_led_rd_vld && r_led_rd_data[WORD_W-1];
    assign e_fault = r_led_rd_vld && r_led_rd_data[WORD_W-2];
    assign e_cnt   = r_led_rd_vld ? r_led_rd_data[DELAY_BITS-1:0] : '0;

    // The swept entry expires on this step and its LED is in range. This
    // does not depend on the step command, so the stall has no loop.
    assign sw_expire = (e_cnt == DELAY_BITS'(1)) &&
                       led_ok_f(i_led_count, UNIT_W'(r_sw_unit), LED_COUNT_W'(r_sw_led));

    always_comb begin
        case (i_cmd.led_sel)
            LRD_ITEM:  rd_addr = item_slot;
            LRD_MAP:   rd_addr = mapped_slot;
            LRD_FIRST: rd_addr = '0;
            LRD_NEXT:  rd_addr = r_led_addr + LS_W'(1);
            default:   rd_addr = '0;
        endcase
    end

    // One write per cycle at the address last read.
    always_comb begin
        wr_en      = 1'b0;
        wr_data    = {e_seen, e_fault, e_cnt};
        res_need   = 1'b0;
        res_bright = BRIGHT_FULL;
        if (i_cmd.act_wr) begin
            wr_en = !e_fault;
            wr_data = {1'b1, e_fault, (e_cnt == '0) ? i_act_delay : e_cnt};
        end else if (i_cmd.fault_wr) begin
            wr_en   = 1'b1;
            wr_data = {e_seen, r_faulty, e_cnt};
        end else if (i_cmd.sweep_step && (e_cnt != '0)) begin
            wr_en   = 1'b1;
            wr_data = {e_seen, e_fault, e_cnt - DELAY_BITS'(1)};
            if (sw_expire) begin
                res_need = 1'b1;
                if (e_seen) begin
                    wr_data    = {1'b0, e_fault, i_hold_delay};
                    res_bright = BRIGHT_HALF;
                end else begin
                    res_bright = e_fault ? BRIGHT_OFF : BRIGHT_FULL;
                end
            end
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.cmd        = r_cmd;
        o_sts.unit_ok    = unit_ok;
        o_sts.led_ok     = led_ok;
        o_sts.disk_ok    = disk_ok;
        o_sts.act_ok     = act_ok;
        o_sts.out_free   = out_free;
        o_sts.sw_stall   = sw_expire && r_pend_valid && !out_free;
        o_sts.sw_last    = r_led_addr == LS_W'(LED_SLOTS - 1);
        o_sts.pend_valid = r_pend_valid;
    end

    // Item, memory data and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd    <= i_cmd_code;
            r_unit   <= i_unit;
            r_disk   <= i_disk;
            r_led    <= i_led;
            r_faulty <= i_faulty;
            r_level  <= i_level;
        end
        if (i_cmd.map_rd) begin
            r_map_rd_data <= map_mem[map_slot];
            r_map_rd_vld  <= r_map_vld[map_slot];
        end
        if (i_cmd.map_wr) begin
            map_mem[map_slot] <= r_led[LED_W-1:0];
        end
        if (i_cmd.led_rd) begin
            r_led_addr    <= rd_addr;
            r_led_rd_data <= led_mem[rd_addr];
            r_led_rd_vld  <= r_led_vld[rd_addr];
        end
        if (wr_en) begin
            led_mem[r_led_addr] <= wr_data;
        end
        if (i_cmd.sweep_start) begin
            r_sw_unit <= '0;
            r_sw_led  <= '0;
        end else if (i_cmd.sweep_step) begin
            if (r_sw_led == LED_W'(LEDS_PER_UNIT - 1)) begin
                r_sw_led  <= '0;
                r_sw_unit <= r_sw_unit + US_W'(1);
            end else begin
                r_sw_led <= r_sw_led + LED_W'(1);
            end
        end
        if (i_cmd.direct_emit) begin
            r_out_unit   <= r_unit;
            r_out_led    <= r_led;
            r_out_bright <= r_level;
            r_out_last   <= 1'b1;
        end else if (i_cmd.sweep_step && res_need) begin
            // The output register only takes a result that is really pending;
            // otherwise it may still hold an earlier item's result.
            if (r_pend_valid) begin
                r_out_unit   <= r_pend_unit;
                r_out_led    <= r_pend_led;
                r_out_bright <= r_pend_bright;
                r_out_last   <= 1'b0;
            end
            r_pend_unit   <= UNIT_W'(r_sw_unit);
            r_pend_led    <= LEDN_W'(r_sw_led);
            r_pend_bright <= res_bright;
        end else if (i_cmd.flush) begin
            r_out_unit   <= r_pend_unit;
            r_out_led    <= r_pend_led;
            r_out_bright <= r_pend_bright;
            r_out_last   <= 1'b1;
        end
    end

    // Valid bits and handshake state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld    <= '0;
            r_led_vld    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.map_wr) begin
                r_map_vld[map_slot] <= 1'b1;
            end
            if (i_cmd.map_clr) begin
                for (int i = 0; i < MAP_SLOTS; i++) begin
                    if (i / DISKS_PER_UNIT == int'(r_unit)) begin
                        r_map_vld[i] <= 1'b0;
                    end
                end
            end
            if (wr_en) begin
                r_led_vld[r_led_addr] <= 1'b1;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.direct_emit || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end
            if (i_cmd.sweep_step && res_need) begin
                r_pend_valid <= 1'b1;
                if (r_pend_valid) begin
                    r_out_valid <= 1'b1;
                end
            end
            if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_unit   = r_out_unit;
    assign o_out_led    = r_out_led;
    assign o_brightness = r_out_bright;
    assign o_last       = r_out_last;

endmodule
`default_nettype wire

// ===== design/disk_activity_led_blinker_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// disk_activity_led_blinker_unit: disk activity LED blinker, top level
// Blinks the disk LEDs of several enclosure units from disk activity and a
// periodic tick, and passes direct brightness settings through.
// ----------------------------------------------------------------------------
// The block takes one command item at a time and reports each LED brightness
// change as one result item; the last result caused by an item carries
// o_last. A tick item visits the LEDs in turn because the per-LED countdowns
// live in a memory with one read and one write port; the sweep visits one LED
// per cycle unless results back up at the output. Activity reads the disk
// map and then the mapped LED's entry, and is dropped when the map gives no
// valid LED; set fault reads the LED's entry and writes it back, and set
// fault and direct brightness are dropped for an invalid LED (direct
// brightness also waits for a free output register).
// After reset every LED is idle and every disk is unmapped at once: valid bits
// mark written entries, so there is no clearing pass. The configuration
// registers may be written only while no item is in progress.
module disk_activity_led_blinker_unit #(
    parameter int UNITS          = 4,
    parameter int LEDS_PER_UNIT  = 16,
    parameter int DISKS_PER_UNIT = 16,
    parameter int DELAY_BITS     = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [dalb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [dalb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [dalb_pkg::CMD_W-1:0]        i_cmd,
    input  wire logic [dalb_pkg::UNIT_W-1:0]       i_unit,
    input  wire logic [dalb_pkg::DISK_W-1:0]       i_disk,
    input  wire logic [dalb_pkg::LEDN_W-1:0]       i_led,
    input  wire logic                              i_faulty,
    input  wire logic [dalb_pkg::LEVEL_W-1:0]      i_level,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [dalb_pkg::UNIT_W-1:0]            o_out_unit,
    output logic [dalb_pkg::LEDN_W-1:0]            o_out_led,
    output logic [dalb_pkg::LEVEL_W-1:0]           o_brightness,
    output logic                                   o_last
);
    import dalb_pkg::*;

    // Delays are compared at a width that holds both the register and the
    // countdown, so any countdown width saturates correctly.
    localparam int EW = (DELAY_BITS > CFG_DATA_W) ? DELAY_BITS : CFG_DATA_W;
    localparam logic [EW-1:0] EMAX = EW'((1 << DELAY_BITS) - 1);

    logic [UNITS-1:0][LED_COUNT_W-1:0] r_led_count;
    logic [CFG_DATA_W-1:0]             r_act_delay;
    logic [CFG_DATA_W-1:0]             r_hold_delay;
    logic [DELAY_BITS-1:0]             act_eff;
    logic [DELAY_BITS-1:0]             hold_eff;
    logic [EW-1:0]                     act_ext;
    logic [EW-1:0]                     hold_ext;
    t_dp_cmd                           dp_cmd;
    t_dp_sts                           dp_sts;

    // Configuration registers. Unit counts beyond the configured units are
    // simply not stored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count  <= '0;
            r_act_delay  <= ACT_DELAY_RESET;
            r_hold_delay <= HOLD_DELAY_RESET;
        end else if (i_cfg_we) begin
            for (int u = 0; u < UNITS; u++) begin
                if (i_cfg_idx == CFG_LED_COUNT0 + CFG_IDX_W'(u)) begin
                    r_led_count[u] <= i_cfg_data[LED_COUNT_W-1:0];
                end
            end
            if (i_cfg_idx == CFG_ACT_DELAY) begin
                r_act_delay <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_HOLD_DELAY) begin
                r_hold_delay <= i_cfg_data;
            end
        end
    end

    // A delay of zero acts as one, and a delay the countdown cannot hold is
    // clipped to the countdown's largest value.
    always_comb begin
        act_ext  = EW'(r_act_delay);
        hold_ext = EW'(r_hold_delay);
        if (act_ext == '0) begin
            act_ext = EW'(1);
        end else if (act_ext > EMAX) begin
            act_ext = EMAX;
        end
        if (hold_ext == '0) begin
            hold_ext = EW'(1);
        end else if (hold_ext > EMAX) begin
            hold_ext = EMAX;
        end
        act_eff  = DELAY_BITS'(act_ext);
        hold_eff = DELAY_BITS'(hold_ext);
    end

    dalb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd),
        .i_sts      (dp_sts)
    );

    dalb_datapath #(
        .UNITS          (UNITS),
        .LEDS_PER_UNIT  (LEDS_PER_UNIT),
        .DISKS_PER_UNIT (DISKS_PER_UNIT),
        .DELAY_BITS     (DELAY_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_cmd_code   (i_cmd),
        .i_unit       (i_unit),
        .i_disk       (i_disk),
        .i_led        (i_led),
        .i_faulty     (i_faulty),
        .i_level      (i_level),
        .i_led_count  (r_led_count),
        .i_act_delay  (act_eff),
        .i_hold_delay (hold_eff),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_unit   (o_out_unit),
        .o_out_led    (o_out_led),
        .o_brightness (o_brightness),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire
